// ===== sv/lookalike_domain_matcher_core_macros.svh =====
// Assertion macros for the lookalike domain matcher.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef LOOKALIKE_DOMAIN_MATCHER_CORE_MACROS_SVH
`define LOOKALIKE_DOMAIN_MATCHER_CORE_MACROS_SVH

// same-cycle implication
`define LDM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LDM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ldm_pkg.sv =====
// Shared types and constants of the lookalike domain matcher.
// No dependencies; compile first.
package ldm_pkg;

  localparam int MaxLenDef = 64;
  localparam int SymW      = 8;
  localparam int FuncW     = 2;
  localparam int CfgW      = 8;
  localparam int CfgIdxW   = 2;
  localparam int OutW      = 7;

  localparam logic [CfgW-1:0] DistLimitRst = 8'd5;
  localparam logic [CfgW-1:0] RatioNumRst  = 8'd6;
  localparam logic [CfgW-1:0] RatioDenRst  = 8'd10;

  typedef enum logic [FuncW-1:0] {
    FUNC_DOMAIN = 2'd0,
    FUNC_HOST   = 2'd1,
    FUNC_REF    = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIST_LIMIT = 2'd0,
    CFG_RATIO_NUM  = 2'd1,
    CFG_RATIO_DEN  = 2'd2
  } cfg_idx_e;

  // control part of a reference token moving down the cell chain
  typedef struct packed {
    logic            valid;
    logic            upd;
    logic            last;
    logic            ovf;
    logic [SymW-1:0] symbol;
  } tok_ctl_t;

  // probe load / restart broadcast to all cells
  typedef struct packed {
    logic            restart;
    logic            dom_we;
    logic            host_we;
    logic [SymW-1:0] symbol;
  } ld_t;

endpackage

// ===== sv/ldm_in_if.sv =====
// Input channel of the lookalike domain matcher: valid/ready plus one item.
// Depends on ldm_pkg.
interface ldm_in_if import ldm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [SymW-1:0]  symbol;
  logic             last;

  modport source (output valid, func, symbol, last, input ready);
  modport sink   (input valid, func, symbol, last, output ready);
endinterface

// ===== sv/ldm_out_if.sv =====
// Result channel of the lookalike domain matcher: valid/ready plus one item.
// Depends on ldm_pkg.
interface ldm_out_if import ldm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OutW-1:0] edit_dist;
  logic [OutW-1:0] common_length;
  logic [OutW-1:0] reference_length;
  logic            lookalike;
  logic            overflow;

  modport source (output valid, edit_dist, common_length, reference_length,
                  lookalike, overflow, input ready);
  modport sink   (input valid, edit_dist, common_length, reference_length,
                  lookalike, overflow, output ready);
endinterface

// ===== sv/ldm_cell.sv =====
// One column cell of the matcher chain: holds one probe domain byte, one probe
// host byte, one distance entry and one substring entry. Depends on ldm_pkg.
module ldm_cell import ldm_pkg::*; #(
  parameter int MAX_LEN = MaxLenDef,
  parameter int IDX     = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  ld_t                                ld_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]       dom_cnt_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]       host_cnt_i,
  input  tok_ctl_t                           ctl_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]       d_new_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]       d_old_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]       s_old_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]       row_max_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]       dist_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]       len_i,
  output tok_ctl_t                           ctl_o,
  output logic [$clog2(MAX_LEN+1)-1:0]       d_new_o,
  output logic [$clog2(MAX_LEN+1)-1:0]       d_old_o,
  output logic [$clog2(MAX_LEN+1)-1:0]       s_old_o,
  output logic [$clog2(MAX_LEN+1)-1:0]       row_max_o,
  output logic [$clog2(MAX_LEN+1)-1:0]       dist_o,
  output logic [$clog2(MAX_LEN+1)-1:0]       len_o
);

  localparam int CntW = $clog2(MAX_LEN+1);
  localparam logic [CntW-1:0] MyIdx  = CntW'(IDX);
  localparam logic [CntW-1:0] WrSlot = CntW'(IDX-1);

  logic [SymW-1:0] dom_byte_q, host_byte_q;
  logic [CntW-1:0] d_q, s_q;
  tok_ctl_t        ctl_q;
  logic [CntW-1:0] d_new_q, d_old_q, s_old_q, row_max_q, dist_q, len_q;

  logic            upd;
  logic [CntW-1:0] min_ul, min_all, d_calc, s_calc, d_eff, s_eff;
  logic [CntW-1:0] row_max_d, dist_d;

  always_comb begin
    upd     = ctl_i.valid && ctl_i.upd;
    min_ul  = (d_q < d_new_i) ? d_q : d_new_i;
    min_all = (d_old_i < min_ul) ? d_old_i : min_ul;
    d_calc  = (dom_byte_q == ctl_i.symbol) ? d_old_i : min_all + 1'b1;
    s_calc  = (host_byte_q == ctl_i.symbol) ? s_old_i + 1'b1 : '0;
    d_eff   = upd ? d_calc : d_q;
    s_eff   = upd ? s_calc : s_q;
    // only columns inside the host probe count toward the row maximum
    row_max_d = (upd && (MyIdx <= host_cnt_i) && (s_calc > row_max_i)) ? s_calc : row_max_i;
    dist_d    = (MyIdx == dom_cnt_i) ? d_eff : dist_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      d_q   <= MyIdx;
      s_q   <= '0;
    end else begin
      if (adv_i) begin
        ctl_q <= ctl_i;
      end
      if (ld_i.restart) begin
        d_q <= MyIdx;
        s_q <= '0;
      end else if (adv_i && ctl_i.valid) begin
        // drop back to the row start once the last byte has passed
        d_q <= ctl_i.last ? MyIdx : d_eff;
        s_q <= ctl_i.last ? '0 : s_eff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_new_q   <= d_eff;
      d_old_q   <= d_q;
      s_old_q   <= s_q;
      row_max_q <= row_max_d;
      dist_q    <= dist_d;
      len_q     <= len_i;
    end
    if (ld_i.dom_we && dom_cnt_i == WrSlot) begin
      dom_byte_q <= ld_i.symbol;
    end
    if (ld_i.host_we && host_cnt_i == WrSlot) begin
      host_byte_q <= ld_i.symbol;
    end
  end

  assign ctl_o     = ctl_q;
  assign d_new_o   = d_new_q;
  assign d_old_o   = d_old_q;
  assign s_old_o   = s_old_q;
  assign row_max_o = row_max_q;
  assign dist_o    = dist_q;
  assign len_o     = len_q;

endmodule

// ===== sv/lookalike_domain_matcher_core.sv =====
// Lookalike domain matcher: edit distance and longest common substring per reference.
// Reference bytes: one per cycle while the chain is not stalled; a result passes through the
// MAX_LEN-cell skewed chain, one cell per advance, and then into the result register.
// Probe load and clear items wait until the chain is empty.
// A full, untaken result register stalls the whole chain and the input.
// Reset: counts, flags and rows clear (rows to column indices); limit 5, ratio 6/10.
`include "lookalike_domain_matcher_core_macros.svh"

module lookalike_domain_matcher_core import ldm_pkg::*; #(
  parameter int MAX_LEN = MaxLenDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ldm_in_if.sink             in_ch,
  ldm_out_if.source          out_ch,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int CntW  = $clog2(MAX_LEN+1);
  localparam int ProdW = CntW + CfgW;
  localparam int ExtW  = (CntW > OutW) ? CntW : OutW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_LEN);

  // configuration registers
  logic [CfgW-1:0] dist_limit_q, ratio_num_q, ratio_den_q;

  // probe and reference bookkeeping
  logic [CntW-1:0] dom_cnt_q, host_cnt_q, ref_cnt_q, best_q;
  logic            probe_ovf_q, ref_drop_q;

  // result register
  logic            out_valid_q;
  logic [OutW-1:0] out_dist_q, out_common_q, out_len_q;
  logic            out_look_q, out_ovf_q;

  // chain wiring: slot 0 is the head, slot MAX_LEN the tail
  tok_ctl_t        ctl       [0:MAX_LEN];
  logic [CntW-1:0] d_new     [0:MAX_LEN];
  logic [CntW-1:0] d_old     [0:MAX_LEN];
  logic [CntW-1:0] s_old     [0:MAX_LEN];
  logic [CntW-1:0] row_max   [0:MAX_LEN];
  logic [CntW-1:0] dist_pipe [0:MAX_LEN];
  logic [CntW-1:0] len       [0:MAX_LEN];
  logic [MAX_LEN-1:0] cell_busy;

  logic            busy, adv, accept, ref_take, room, result_take;
  logic [CntW-1:0] row;
  ld_t             ld;
  logic [CntW-1:0] best_d;
  logic [ProdW-1:0] lhs, rhs;
  logic [ExtW-1:0] dist_ext, best_ext, len_ext;
  logic            look;

  // ---------------------------------------------------------------------------
  // Handshake. Reference bytes stream in while the chain is moving; anything
  // that rewrites the probe waits for the chain to drain.
  // ---------------------------------------------------------------------------
  assign busy         = |cell_busy;
  assign adv          = !out_valid_q || out_ch.ready;
  assign in_ch.ready  = adv && (in_ch.func == FUNC_REF || !busy);
  assign accept       = in_ch.valid && in_ch.ready;
  assign ref_take     = accept && in_ch.func == FUNC_REF;
  assign room         = ref_cnt_q < MaxCnt;
  // a byte past MAX_LEN is dropped: no cell update, but the token still runs
  // so that a last byte produces its result in order
  assign row          = room ? ref_cnt_q + 1'b1 : ref_cnt_q;

  // probe load / restart broadcast
  always_comb begin
    ld.restart = accept && in_ch.func != FUNC_REF;
    ld.dom_we  = accept && in_ch.func == FUNC_DOMAIN && dom_cnt_q < MaxCnt;
    ld.host_we = accept && in_ch.func == FUNC_HOST && host_cnt_q < MaxCnt;
    ld.symbol  = in_ch.symbol;
  end

  // ---------------------------------------------------------------------------
  // Head of the chain: column zero of the distance row is just the row number.
  // ---------------------------------------------------------------------------
  assign ctl[0]     = '{valid:  ref_take,
                        upd:    room,
                        last:   in_ch.last,
                        ovf:    probe_ovf_q || ref_drop_q || !room,
                        symbol: in_ch.symbol};
  assign d_new[0]   = row;
  assign d_old[0]   = ref_cnt_q;
  assign s_old[0]   = '0;
  assign row_max[0] = '0;
  // empty domain probe: distance is the reference length
  assign dist_pipe[0] = row;
  assign len[0]       = row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dom_cnt_q   <= '0;
      host_cnt_q  <= '0;
      probe_ovf_q <= 1'b0;
      ref_cnt_q   <= '0;
      ref_drop_q  <= 1'b0;
    end else if (accept) begin
      case (in_ch.func)
        FUNC_DOMAIN: begin
          ref_cnt_q  <= '0;
          ref_drop_q <= 1'b0;
          if (dom_cnt_q < MaxCnt) begin
            dom_cnt_q <= dom_cnt_q + 1'b1;
          end else begin
            probe_ovf_q <= 1'b1;
          end
        end
        FUNC_HOST: begin
          ref_cnt_q  <= '0;
          ref_drop_q <= 1'b0;
          if (host_cnt_q < MaxCnt) begin
            host_cnt_q <= host_cnt_q + 1'b1;
          end else begin
            probe_ovf_q <= 1'b1;
          end
        end
        FUNC_REF: begin
          if (in_ch.last) begin
            ref_cnt_q  <= '0;
            ref_drop_q <= 1'b0;
          end else if (room) begin
            ref_cnt_q <= row;
          end else begin
            ref_drop_q <= 1'b1;
          end
        end
        default: begin
          // clear probe and abandon any reference in progress
          dom_cnt_q   <= '0;
          host_cnt_q  <= '0;
          probe_ovf_q <= 1'b0;
          ref_cnt_q   <= '0;
          ref_drop_q  <= 1'b0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain. Cell g owns distance column g and substring column g-1; each
  // byte reaches cell g through the registers of cells 1 to g-1, moving only on advance.
  // ---------------------------------------------------------------------------
  for (genvar g = 1; g <= MAX_LEN; g++) begin : g_cell
    ldm_cell #(
      .MAX_LEN (MAX_LEN),
      .IDX     (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .ld_i      (ld),
      .dom_cnt_i (dom_cnt_q),
      .host_cnt_i(host_cnt_q),
      .ctl_i     (ctl[g-1]),
      .d_new_i   (d_new[g-1]),
      .d_old_i   (d_old[g-1]),
      .s_old_i   (s_old[g-1]),
      .row_max_i (row_max[g-1]),
      .dist_i    (dist_pipe[g-1]),
      .len_i     (len[g-1]),
      .ctl_o     (ctl[g]),
      .d_new_o   (d_new[g]),
      .d_old_o   (d_old[g]),
      .s_old_o   (s_old[g]),
      .row_max_o (row_max[g]),
      .dist_o    (dist_pipe[g]),
      .len_o     (len[g])
    );
    assign cell_busy[g-1] = ctl[g].valid;
  end

  // ---------------------------------------------------------------------------
  // Tail: fold each row maximum into the running best, and on the last byte form the
  // result and the lookalike test (dist <= limit or lcs * den >= num * len).
  // ---------------------------------------------------------------------------
  assign result_take = adv && ctl[MAX_LEN].valid && ctl[MAX_LEN].last;
  assign best_d      = (row_max[MAX_LEN] > best_q) ? row_max[MAX_LEN] : best_q;

  always_comb begin
    lhs      = ProdW'(best_d) * ProdW'(ratio_den_q);
    rhs      = ProdW'(ratio_num_q) * ProdW'(len[MAX_LEN]);
    look     = (ProdW'(dist_pipe[MAX_LEN]) <= ProdW'(dist_limit_q)) || (lhs >= rhs);
    dist_ext = ExtW'(dist_pipe[MAX_LEN]);
    best_ext = ExtW'(best_d);
    len_ext  = ExtW'(len[MAX_LEN]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld.restart) begin
        best_q <= '0;
      end else if (adv && ctl[MAX_LEN].valid) begin
        best_q <= ctl[MAX_LEN].last ? '0 : best_d;
      end
      if (result_take) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_take) begin
      out_dist_q   <= dist_ext[OutW-1:0];
      out_common_q <= best_ext[OutW-1:0];
      out_len_q    <= len_ext[OutW-1:0];
      out_look_q   <= look;
      out_ovf_q    <= ctl[MAX_LEN].ovf;
    end
  end

  assign out_ch.valid            = out_valid_q;
  assign out_ch.edit_dist        = out_dist_q;
  assign out_ch.common_length    = out_common_q;
  assign out_ch.reference_length = out_len_q;
  assign out_ch.lookalike        = out_look_q;
  assign out_ch.overflow         = out_ovf_q;

  // ---------------------------------------------------------------------------
  // Configuration writes; an index past the list is ignored.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_limit_q <= DistLimitRst;
      ratio_num_q  <= RatioNumRst;
      ratio_den_q  <= RatioDenRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIST_LIMIT: dist_limit_q <= cfg_data_i;
        CFG_RATIO_NUM:  ratio_num_q  <= cfg_data_i;
        CFG_RATIO_DEN:  ratio_den_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `LDM_ASSERT_IMP(a_load_when_drained, accept && in_ch.func != FUNC_REF, !busy, "probe item, busy")
  `LDM_ASSERT_IMP(a_ref_cnt_bound, 1'b1, ref_cnt_q <= MaxCnt && dom_cnt_q <= MaxCnt, "count high")
  `LDM_ASSERT_NXT(a_result_lands, result_take, out_valid_q, "last token without result")
  `LDM_ASSERT_NXT(a_best_cleared, result_take, best_q == '0, "maximum not cleared")

endmodule
